/* hdl/bb3_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the 3x3 border-average box blur
// no dependencies

package bb3_pkg;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 16;
    localparam int ROW_BITS       = 17;
    localparam int CHAN_BITS      = 8;
    localparam int PIX_BITS       = 24;
    localparam int SUM_BITS       = 12;
    localparam int CNT_BITS       = 4;
    localparam int RECIP_BITS     = 17;
    localparam int RECIP_SHIFT    = 16;
    localparam int OP_COL_BITS    = 13;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // one unit of work for the back end: optional line push, optional window average
    typedef struct packed {
        logic                   push;
        logic                   emit;
        logic                   last;
        logic [2:0]             row_ok;
        logic [2:0]             col_ok;
        logic [OP_COL_BITS-1:0] col;
        logic [PIX_BITS-1:0]    pix;
    } op_t;

    // ceil(2^16 / n) for every pixel count a window can have
    function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] n);
        logic [RECIP_BITS-1:0] m;
        unique case (n)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

/* hdl/bb3_pix_if.sv */
`timescale 1ns / 1ps
// input channel: valid/ready with one pixel or flush item
// depends on bb3_pkg

interface bb3_pix_if;
    import bb3_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;

    modport source (output valid, kind, red, green, blue, input ready);
    modport sink   (input valid, kind, red, green, blue, output ready);
endinterface

/* hdl/bb3_blur_if.sv */
`timescale 1ns / 1ps
// output channel: valid/ready with one blurred pixel
// depends on bb3_pkg

interface bb3_blur_if;
    import bb3_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] blur_red;
    logic [CHAN_BITS-1:0] blur_green;
    logic [CHAN_BITS-1:0] blur_blue;
    logic                 frame_last;

    modport source (output valid, blur_red, blur_green, blur_blue, frame_last, input ready);
    modport sink   (input valid, blur_red, blur_green, blur_blue, frame_last, output ready);
endinterface

/* hdl/bb3_queue.sv */
`timescale 1ns / 1ps
// small fifo of work units between front and back end
// depends on bb3_pkg

module bb3_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  bb3_pkg::op_t wr_op,
    output logic         full,
    input  logic         rd_en,
    output bb3_pkg::op_t rd_op,
    output logic         empty
);
    import bb3_pkg::*;

    op_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wp_reg;
    logic [QUEUE_AW-1:0] rp_reg;
    logic [QUEUE_AW:0]   fill_reg;

    assign full  = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign rd_op = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            slot_reg[wp_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            fill_reg <= fill_reg + (QUEUE_AW+1)'(wr_en && !full)
                                 - (QUEUE_AW+1)'(rd_en && !empty);
        end
    end
endmodule

/* hdl/bb3_front.sv */
`timescale 1ns / 1ps
// front end: configuration, stream position and splitting items into work units
// depends on bb3_pkg, bb3_pix_if

module bb3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [bb3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    bb3_pix_if.sink                              pix_in,
    output logic                                 enq_valid,
    output bb3_pkg::op_t                         enq_op,
    input  logic                                 enq_full
);
    import bb3_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef enum logic {F_IDLE, F_BUSY} fstate_t;

    fstate_t                state_reg;
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [CW-1:0]          col_reg;
    logic [ROW_BITS-1:0]    row_reg;
    logic                   kind_reg;
    logic [PIX_BITS-1:0]    pix_reg;
    logic                   end_done_reg;
    logic                   emitted_reg;
    logic                   second_reg;

    logic [WW-1:0]       eff_w;
    logic [ROW_BITS-1:0] eff_h;
    logic                bad, need_end, in_img, mid, c_zero, is_last, fire;
    logic                adv_done, end_done_next, emitted_now, restart, again;
    logic [CW:0]         col_inc;
    logic [CW-1:0]       col_next;
    logic [ROW_BITS-1:0] row_next;
    logic                drop;

    always_comb
    begin
        if (width_reg == '0)
            eff_w = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_reg);
        eff_h = (height_reg == '0) ? ROW_BITS'(1) : ROW_BITS'(height_reg);
    end

    assign pix_in.ready = (state_reg == F_IDLE);
    assign drop = (pix_in.kind == KIND_PIXEL) ? (row_reg >= eff_h) : (row_reg < eff_h);

    always_comb
    begin
        c_zero   = (col_reg == '0);
        bad      = ({1'b0, row_reg} > ({1'b0, eff_h} + 1'b1));
        need_end = !end_done_reg && c_zero && (row_reg >= ROW_BITS'(2));
        in_img   = (row_reg <= eff_h);
        mid      = !c_zero && (row_reg >= ROW_BITS'(1));
        is_last = (row_reg == eff_h + 1'b1);

        enq_valid     = 1'b0;
        enq_op        = '0;
        enq_op.col    = OP_COL_BITS'(col_reg);
        enq_op.pix    = pix_reg;
        adv_done      = 1'b0;
        end_done_next = end_done_reg;
        restart       = 1'b0;

        if (state_reg == F_BUSY)
        begin
            if (bad)
            begin
                adv_done = 1'b1;
                restart  = 1'b1;
            end
            else if (need_end)
            begin
                // right-edge pixel of the row two above, window before the push
                enq_valid        = 1'b1;
                enq_op.emit      = 1'b1;
                enq_op.last      = is_last;
                enq_op.row_ok[0] = (row_reg >= ROW_BITS'(3));
                enq_op.row_ok[1] = 1'b1;
                enq_op.row_ok[2] = in_img;
                enq_op.col_ok[0] = 1'b0;
                enq_op.col_ok[1] = (32'(eff_w) >= 32'd2);
                enq_op.col_ok[2] = 1'b1;
                if (!enq_full)
                begin
                    if (in_img)
                        end_done_next = 1'b1;
                    else
                    begin
                        adv_done = 1'b1;
                        restart  = is_last;
                    end
                end
            end
            else if (in_img)
            begin
                enq_valid        = 1'b1;
                enq_op.push      = 1'b1;
                enq_op.emit      = mid;
                enq_op.row_ok[0] = (row_reg >= ROW_BITS'(2));
                enq_op.row_ok[1] = 1'b1;
                enq_op.row_ok[2] = (row_reg < eff_h);
                enq_op.col_ok[0] = (32'(col_reg) >= 32'd2);
                enq_op.col_ok[1] = 1'b1;
                enq_op.col_ok[2] = 1'b1;
                adv_done         = !enq_full;
            end
            else
            begin
                adv_done = 1'b1;
            end
        end

        fire        = enq_valid && !enq_full;
        emitted_now = emitted_reg || (fire && enq_op.emit);

        col_inc = {1'b0, col_reg} + 1'b1;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (32'(col_inc) >= 32'(eff_w))
        begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end
        else
        begin
            col_next = CW'(col_inc);
            row_next = row_reg;
        end

        // a flush that produced nothing steps once more
        again = (kind_reg == KIND_FLUSH) && !emitted_now && !second_reg && (row_next >= eff_h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            kind_reg     <= KIND_PIXEL;
            pix_reg      <= '0;
            end_done_reg <= 1'b0;
            emitted_reg  <= 1'b0;
            second_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                col_reg <= '0;
                row_reg <= '0;
                if (cfg_index == CFG_IMAGE_WIDTH)
                    width_reg <= WIDTH_BITS'(cfg_data);
                else
                    height_reg <= cfg_data;
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (pix_in.valid && !drop)
                    begin
                        state_reg    <= F_BUSY;
                        kind_reg     <= pix_in.kind;
                        pix_reg      <= (pix_in.kind == KIND_PIXEL) ?
                                        {pix_in.red, pix_in.green, pix_in.blue} : '0;
                        end_done_reg <= 1'b0;
                        emitted_reg  <= 1'b0;
                        second_reg   <= 1'b0;
                    end
                end
                F_BUSY:
                begin
                    end_done_reg <= (adv_done && again) ? 1'b0 : end_done_next;
                    emitted_reg  <= emitted_now;
                    if (adv_done)
                    begin
                        col_reg <= col_next;
                        row_reg <= row_next;
                        if (again)
                        begin
                            second_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= F_IDLE;
                        end
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

/* hdl/bb3_back.sv */
`timescale 1ns / 1ps
// back end: line buffers, 3x3 window, masked sums and rounded division
// depends on bb3_pkg, bb3_blur_if

module bb3_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          deq_empty,
    input  bb3_pkg::op_t  deq_op,
    output logic          deq_en,
    bb3_blur_if.source    blur_out
);
    import bb3_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    typedef enum logic [1:0] {B_IDLE, B_UPD, B_SUM, B_DIV} bstate_t;

    bstate_t                   state_reg;
    op_t                       op_reg;
    logic [2*PIX_BITS-1:0]     line_mem [MAX_WIDTH];
    logic [2*PIX_BITS-1:0]     rd_reg;
    logic [PIX_BITS-1:0]       win_reg [3][3];
    logic [SUM_BITS-1:0]       sum_reg [3];
    logic [CNT_BITS-1:0]       cnt_reg;
    logic                      last_reg;
    logic                      out_valid_reg;
    logic [CHAN_BITS-1:0]      out_chan_reg [3];
    logic                      out_last_reg;

    logic [SUM_BITS-1:0]       sum_next [3];
    logic [CNT_BITS-1:0]       cnt_next;
    logic [CHAN_BITS-1:0]      quot [3];
    logic [SUM_BITS-1:0]       biased;
    logic [SUM_BITS+RECIP_BITS-1:0] prod;
    logic                      load_out;

    assign deq_en = (state_reg == B_IDLE) && !deq_empty;
    assign load_out = (state_reg == B_DIV) && (!out_valid_reg || blur_out.ready);

    assign blur_out.valid      = out_valid_reg;
    assign blur_out.blur_red   = out_chan_reg[0];
    assign blur_out.blur_green = out_chan_reg[1];
    assign blur_out.blur_blue  = out_chan_reg[2];
    assign blur_out.frame_last = out_last_reg;

    // line buffer: high half the row two above, low half the row above
    always_ff @(posedge clk)
    begin
        if (deq_en)
        begin
            rd_reg <= line_mem[deq_op.col[AW-1:0]];
        end
        if (state_reg == B_UPD && op_reg.push)
        begin
            line_mem[op_reg.col[AW-1:0]] <= {rd_reg[PIX_BITS-1:0], op_reg.pix};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_UPD && op_reg.push)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_reg[2*PIX_BITS-1:PIX_BITS];
            win_reg[1][2] <= rd_reg[PIX_BITS-1:0];
            win_reg[2][2] <= op_reg.pix;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum_next[k] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (op_reg.row_ok[i] && op_reg.col_ok[j])
                begin
                    sum_next[0] = sum_next[0] + SUM_BITS'(win_reg[i][j][23:16]);
                    sum_next[1] = sum_next[1] + SUM_BITS'(win_reg[i][j][15:8]);
                    sum_next[2] = sum_next[2] + SUM_BITS'(win_reg[i][j][7:0]);
                end
            end
        end
        cnt_next = CNT_BITS'({2'b00, 2'($countones(op_reg.row_ok))} *
                             {2'b00, 2'($countones(op_reg.col_ok))});
    end

    // rounded mean by reciprocal multiply, exact for sums of up to nine pixels
    always_comb
    begin
        biased = '0;
        prod   = '0;
        for (int k = 0; k < 3; k++)
        begin
            biased  = sum_reg[k] + SUM_BITS'(cnt_reg >> 1);
            prod    = (SUM_BITS+RECIP_BITS)'(biased) *
                      (SUM_BITS+RECIP_BITS)'(recip(cnt_reg));
            quot[k] = prod[RECIP_SHIFT+CHAN_BITS-1:RECIP_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            op_reg        <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]      <= '0;
                out_chan_reg[k] <= '0;
            end
        end
        else
        begin
            if (blur_out.ready && !load_out)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!deq_empty)
                    begin
                        op_reg    <= deq_op;
                        state_reg <= B_UPD;
                    end
                end
                B_UPD:
                begin
                    state_reg <= op_reg.emit ? B_SUM : B_IDLE;
                end
                B_SUM:
                begin
                    for (int k = 0; k < 3; k++)
                        sum_reg[k] <= sum_next[k];
                    cnt_reg   <= cnt_next;
                    last_reg  <= op_reg.last;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    if (load_out)
                    begin
                        for (int k = 0; k < 3; k++)
                            out_chan_reg[k] <= quot[k];
                        out_last_reg  <= last_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule

/* hdl/box_blur_3x3_border_average.sv */
`timescale 1ns / 1ps
// top level of the 3x3 border-average box blur
// depends on bb3_pkg, bb3_pix_if, bb3_blur_if, bb3_queue, bb3_front, bb3_back

// 3x3 box blur over an rgb raster stream. each output channel is the mean of the
// window pixels that lie inside the image (4 at corners, 6 on edges, 9 inside),
// rounded half up. results lag the input by one row plus one pixel, so after the
// last pixel of a frame send flush items (kind = 1) until the transfer with
// frame_last; pixels sent past the frame's input and early flushes are dropped.
// a configuration write restarts the frame. the front end turns an item into work
// units, two when a row start also owes the right-edge pixel two rows up, and a
// flush that produced nothing steps once more. the back end does a line-buffer push
// in its memory read and window update states and adds for an average a masked sum
// and a reciprocal multiply, which waits for the output to be taken; it takes no new
// work unit until it is through with the last one.
// line buffers are not cleared after reset; stale entries are masked out.

module box_blur_3x3_border_average #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [bb3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    bb3_pix_if.sink                            pix_in,
    bb3_blur_if.source                         blur_out
);
    import bb3_pkg::*;

    // work units from the front end into the queue
    logic enq_valid;
    op_t  enq_op;
    logic enq_full;

    // queue head towards the back end
    logic deq_en;
    op_t  deq_op;
    logic deq_empty;

    // front end: register file, stream counters, splits items into work units
    bb3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .enq_valid (enq_valid),
        .enq_op    (enq_op),
        .enq_full  (enq_full)
    );

    // decoupling queue so each side stalls on its own
    bb3_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (enq_valid),
        .wr_op (enq_op),
        .full  (enq_full),
        .rd_en (deq_en),
        .rd_op (deq_op),
        .empty (deq_empty)
    );

    // back end: line buffers, window, averaging and output register
    bb3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .deq_empty (deq_empty),
        .deq_op    (deq_op),
        .deq_en    (deq_en),
        .blur_out  (blur_out)
    );
endmodule

/* tb/tb_box_blur_3x3_border_average.sv */
`timescale 1ns / 1ps
// testbench for the 3x3 border-average box blur: random frames, flushes and noise,
// checked against a scoreboard that recomputes every blurred pixel
// depends on bb3_pkg, bb3_pix_if, bb3_blur_if and box_blur_3x3_border_average

module tb_box_blur_3x3_border_average;
    import bb3_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 32;

    typedef struct {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic                 last;
    } blur_px_t;

    // scoreboard: window predictor plus the queue of blurred pixels still owed
    class blur_scoreboard;
        logic [PIX_BITS-1:0]    line_mem [2*MAX_W];
        logic [PIX_BITS-1:0]    win [3][3];
        logic [WIDTH_BITS-1:0]  width_reg;
        logic [HEIGHT_BITS-1:0] height_reg;
        int                     col_pos;
        int                     row_pos;
        blur_px_t               owed [$];
        int                     errors;
        bit                     last_seen;

        function void clear();
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
            last_seen  = 0;
        endfunction

        function int eff_w();
            int w;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > MAX_W) w = MAX_W;
            return w;
        endfunction

        function int eff_h();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            if (idx == CFG_IMAGE_WIDTH) width_reg = val[WIDTH_BITS-1:0];
            else height_reg = val;
            col_pos = 0;
            row_pos = 0;
        endfunction

        // average the in-image part of the window for pixel (orow, ocol)
        function blur_px_t average(int orow, int ocol, int base, int h, int w);
            blur_px_t res;
            int sr, sg, sb, cnt, r, c;
            sr = 0; sg = 0; sb = 0; cnt = 0;
            for (int i = 0; i < 3; i++)
            begin
                r = orow - 1 + i;
                if (r < 0 || r >= h) continue;
                for (int j = 0; j < 3; j++)
                begin
                    c = base + j;
                    if (c < 0 || c >= w || c < ocol - 1 || c > ocol + 1) continue;
                    sr += win[i][j][23:16];
                    sg += win[i][j][15:8];
                    sb += win[i][j][7:0];
                    cnt++;
                end
            end
            if (cnt == 0) cnt = 1;
            res.red   = 8'((sr + cnt / 2) / cnt);
            res.green = 8'((sg + cnt / 2) / cnt);
            res.blue  = 8'((sb + cnt / 2) / cnt);
            res.last  = (orow == h - 1) && (ocol == w - 1);
            return res;
        endfunction

        // one step of the stream; returns 1 when a blurred pixel is produced
        function bit stream_step(logic [PIX_BITS-1:0] p);
            int w, h, c, r;
            bit got;
            blur_px_t res;
            logic [PIX_BITS-1:0] up2, up1;
            w = eff_w(); h = eff_h(); c = col_pos; r = row_pos; got = 0;
            if (row_pos > h + 1 || col_pos >= w)
            begin
                col_pos = 0;
                row_pos = 0;
                return 0;
            end
            if (c == 0 && r >= 2)
            begin
                res = average(r - 2, w - 1, w - 3, h, w);
                got = 1;
            end
            if (row_pos <= h)
            begin
                up2 = line_mem[MAX_W + c];
                up1 = line_mem[c];
                line_mem[MAX_W + c] = up1;
                line_mem[c] = p;
                for (int i = 0; i < 3; i++)
                begin
                    win[i][0] = win[i][1];
                    win[i][1] = win[i][2];
                end
                win[0][2] = up2;
                win[1][2] = up1;
                win[2][2] = p;
                if (c >= 1 && r >= 1)
                begin
                    res = average(r - 1, c - 1, c - 2, h, w);
                    got = 1;
                end
            end
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (got)
            begin
                owed.push_back(res);
                if (res.last)
                begin
                    last_seen = 1;
                    col_pos = 0;
                    row_pos = 0;
                end
            end
            return got;
        endfunction

        function void note_input(logic kind, logic [PIX_BITS-1:0] p);
            if (kind == KIND_PIXEL)
            begin
                if (row_pos < eff_h()) void'(stream_step(p));
            end
            else if (row_pos >= eff_h())
            begin
                // a flush may land on a dead step at the end of a row; take one more
                if (!stream_step('0) && row_pos >= eff_h()) void'(stream_step('0));
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_result(blur_px_t got);
            blur_px_t exp;
            if (owed.size() == 0)
            begin
                report("blurred pixel with none expected");
                return;
            end
            exp = owed.pop_front();
            if (got.red !== exp.red)
                report($sformatf("blur_red %0d, expected %0d", got.red, exp.red));
            if (got.green !== exp.green)
                report($sformatf("blur_green %0d, expected %0d", got.green, exp.green));
            if (got.blue !== exp.blue)
                report($sformatf("blur_blue %0d, expected %0d", got.blue, exp.blue));
            if (got.last !== exp.last)
                report($sformatf("frame_last %0d, expected %0d", got.last, exp.last));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wen;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    bit                        steady;   // no gaps on either side while set
    int                        idle_cycles;
    int                        stall_left;
    blur_scoreboard            sb;

    bb3_pix_if  pix ();
    bb3_blur_if blur ();

    box_blur_3x3_border_average #(.MAX_WIDTH(MAX_W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix),
        .blur_out  (blur)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int x;
        x = $urandom_range(0, 99);
        if (steady || x < 60) return 0;
        if (x < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one transfer on the pixel channel; valid stays high into a back-to-back item
    task automatic send_item(logic kind);
        int gap;
        logic [PIX_BITS-1:0] p;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        p = PIX_BITS'($urandom());
        pix.valid <= 1'b1;
        pix.kind  <= kind;
        pix.red   <= p[23:16];
        pix.green <= p[15:8];
        pix.blue  <= p[7:0];
        do
            @(posedge clk);
        while (!pix.ready);
        sb.note_input(kind, p);
    endtask

    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // configuration only while the block is idle
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_wen   <= 1'b0;
    endtask

    task automatic set_size(int w, int h);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
    endtask

    // one frame: pixels, optional noise, then flushes until the frame_last transfer
    task automatic run_frame(bit noise);
        int npix;
        npix = sb.eff_w() * sb.eff_h();
        sb.last_seen = 0;
        for (int i = 0; i < npix; i++)
        begin
            if (noise && $urandom_range(0, 19) == 0) send_item(KIND_FLUSH);
            send_item(KIND_PIXEL);
        end
        if (noise && $urandom_range(0, 2) == 0) send_item(KIND_PIXEL);
        while (!sb.last_seen)
        begin
            send_item(KIND_FLUSH);
            if (noise && !sb.last_seen && $urandom_range(0, 9) == 0) send_item(KIND_PIXEL);
        end
    endtask

    // receiver: random stalls, none while steady
    always @(posedge clk)
    begin
        blur_px_t got;
        if (rst_n && blur.valid && blur.ready)
        begin
            got.red   = blur.blur_red;
            got.green = blur.blur_green;
            got.blue  = blur.blur_blue;
            got.last  = blur.frame_last;
            sb.check_result(got);
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            blur.ready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 9) == 0)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
            blur.ready <= 1'b0;
        end
        else
            blur.ready <= 1'b1;
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (blur.valid && blur.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int n_items;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wen     = 1'b0;
        cfg_index   = CFG_IMAGE_WIDTH;
        cfg_data    = '0;
        pix.valid   = 1'b0;
        pix.kind    = KIND_PIXEL;
        pix.red     = '0;
        pix.green   = '0;
        pix.blue    = '0;
        blur.ready  = 1'b0;
        steady      = 1'b0;
        idle_cycles = 0;
        stall_left  = 0;
        sb = new();
        sb.clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset size is one row of 1024, so a short start yields nothing
        steady = 1'b1;
        for (int i = 0; i < 8; i++) send_item(KIND_PIXEL);
        steady = 1'b0;
        set_size(2, 2);
        send_item(KIND_FLUSH);          // early flush, dropped
        run_frame(1'b0);
        send_item(KIND_FLUSH);          // flush after the frame, dropped
        set_size(0, 0);                 // both act as one
        run_frame(1'b0);
        set_size(3, 3);
        run_frame(1'b1);
        set_size(1, 4);
        run_frame(1'b0);
        set_size(5, 1);
        run_frame(1'b0);

        // tallest frame, cut short by a register write part way through
        set_size(3, 65535);
        for (int i = 0; i < 12; i++) send_item(KIND_PIXEL);
        // widest value clamps to the buffer width; abandoned by the next write
        set_size(2047, 2);
        for (int i = 0; i < 8; i++) send_item(KIND_PIXEL);

        // random frames, mostly small
        n_items = 0;
        while (n_items < 420)
        begin
            set_size($urandom_range(1, 9), $urandom_range(1, 6));
            steady = ($urandom_range(0, 4) == 0);
            n_items += sb.eff_w() * sb.eff_h();
            if ($urandom_range(0, 7) == 0)
            begin
                // broken frame: abandoned mid-way by the next write
                for (int i = 0; i < $urandom_range(1, 10); i++) send_item(KIND_PIXEL);
            end
            else
                run_frame(1'b1);
            // hold the sender until all owed pixels are out
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
        steady = 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* box_blur_3x3_border_average.f */
hdl/bb3_pkg.sv
hdl/bb3_pix_if.sv
hdl/bb3_blur_if.sv
hdl/bb3_queue.sv
hdl/bb3_front.sv
hdl/bb3_back.sv
hdl/box_blur_3x3_border_average.sv
tb/tb_box_blur_3x3_border_average.sv
